@@ src/dbpt_pkg.sv @@
// ----------------------------------------------------------------------------
// dbpt_pkg
// Shared types and constants of the backup phase tracker.
// ----------------------------------------------------------------------------
package dbpt_pkg;

    // Defaults for the top-level parameters
    localparam int TAG_WIDTH_DEF       = 22;
    localparam int FRAC_BITS_DEF       = 14;
    localparam int CLOCK_PERIOD_PS_DEF = 8000;

    // Fixed field widths
    localparam int FUNC_W     = 2;
    localparam int SRC_W      = 5;
    localparam int TAG_IN_W   = 22;
    localparam int SHIFT_PS_W = 24;
    localparam int DATA_W     = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Adder renormalization
    localparam logic [DATA_W-1:0]        WRAP_STEP    = 32'd100000000;
    localparam logic signed [DATA_W-1:0] RENORM_LIMIT = 32'sd200000000;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TAG   = 2'd0,
        FUNC_SET   = 2'd1,
        FUNC_START = 2'd2,
        FUNC_STOP  = 2'd3
    } t_func;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_CHANNEL = 2'd0,
        CFG_OUT_CHANNEL = 2'd1,
        CFG_LOCK_MASK   = 2'd2,
        CFG_DIV_TWO     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        t_func                         func;
        logic [SRC_W-1:0]              source;
        logic [TAG_IN_W-1:0]           tag;
        logic signed [SHIFT_PS_W-1:0]  shift_ps;
    } t_item;

    typedef struct packed {
        logic [SRC_W-1:0] ref_channel;
        logic [SRC_W-1:0] out_channel;
        logic             lock_mask_enable;
        logic             divide_by_two;
    } t_cfg;

endpackage

@@ src/dbpt_if.sv @@
// ----------------------------------------------------------------------------
// dbpt channel interfaces
// Request, result and register-write channels of the backup phase tracker.
// ----------------------------------------------------------------------------
interface dbpt_in_if;
    logic                                      valid;
    logic                                      ready;
    logic [dbpt_pkg::FUNC_W-1:0]               func;
    logic [dbpt_pkg::SRC_W-1:0]                source;
    logic [dbpt_pkg::TAG_IN_W-1:0]             tag;
    logic signed [dbpt_pkg::SHIFT_PS_W-1:0]    shift_ps;

    modport src (output valid, func, source, tag, shift_ps, input ready);
    modport snk (input valid, func, source, tag, shift_ps, output ready);
endinterface

interface dbpt_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  status;
    logic                                  busy_res;
    logic signed [dbpt_pkg::DATA_W-1:0]    phase_error;
    logic signed [dbpt_pkg::DATA_W-1:0]    current_shift;

    modport src (output valid, status, busy_res, phase_error, current_shift, input ready);
    modport snk (input valid, status, busy_res, phase_error, current_shift, output ready);
endinterface

interface dbpt_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [dbpt_pkg::CFG_IDX_W-1:0]    index;
    logic [dbpt_pkg::CFG_DATA_W-1:0]   data;

    modport src (output valid, index, data, input ready);
    modport snk (input valid, index, data, output ready);
endinterface

@@ src/dbpt_div_pipe.sv @@
// ----------------------------------------------------------------------------
// dbpt_div_pipe
// Two-stage reciprocal multiplier that turns a picosecond shift into tag units.
// Every request passes through; only set-shift requests use the quotient.
// ----------------------------------------------------------------------------
module dbpt_div_pipe #(
    parameter int FRAC_BITS       = dbpt_pkg::FRAC_BITS_DEF,
    parameter int CLOCK_PERIOD_PS = dbpt_pkg::CLOCK_PERIOD_PS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_valid,
    input  logic                          i_div_two,
    input  dbpt_pkg::t_item               i_item,
    output logic                          o_valid,
    output dbpt_pkg::t_item               o_item,
    output logic [dbpt_pkg::DATA_W-1:0]   o_target
);

    localparam int PS_W    = dbpt_pkg::SHIFT_PS_W;
    localparam int DW      = dbpt_pkg::DATA_W;
    // 2^SH >= 2^PS_W * period keeps the truncated product equal to the exact quotient
    localparam int SH      = PS_W + $clog2(CLOCK_PERIOD_PS);
    localparam int RECIP_W = PS_W + FRAC_BITS + 2;
    localparam int HI_W    = RECIP_W - PS_W;
    localparam int PROD_W  = PS_W + RECIP_W;
    localparam logic [63:0] RECIP =
        ((64'd1 << (SH + FRAC_BITS)) + 64'(CLOCK_PERIOD_PS) - 64'd1) /
        64'(CLOCK_PERIOD_PS);
    localparam logic [PS_W-1:0] RECIP_LO = RECIP[PS_W-1:0];
    localparam logic [HI_W-1:0] RECIP_HI = RECIP[RECIP_W-1:PS_W];

    logic [PS_W-1:0]              mag;
    logic [2*PS_W-1:0]            p_lo;
    logic [RECIP_W-1:0]           p_hi;

    logic                         r_mul_v;
    dbpt_pkg::t_item              r_mul_item;
    logic [2*PS_W-1:0]            r_p_lo;
    logic [RECIP_W-1:0]           r_p_hi;

    logic                         r_fin_v;
    dbpt_pkg::t_item              r_fin_item;
    logic [DW-1:0]                r_fin_target;

    logic [PROD_W-1:0]            prod;
    logic [DW-1:0]                q32;
    logic [DW-1:0]                sval;
    logic [DW-1:0]                sval_rnd;
    logic [DW-1:0]                n_target;

    // magnitude of the shift; the most negative value maps to 2^23
    assign mag = i_item.shift_ps[PS_W-1] ?
                 (PS_W'(0) - i_item.shift_ps) : i_item.shift_ps;

    // reciprocal split in two so each partial product stays narrow
    assign p_lo = (2*PS_W)'(mag) * (2*PS_W)'(RECIP_LO);
    assign p_hi = RECIP_W'(mag) * RECIP_W'(RECIP_HI);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_v <= 1'b0;
        end else if (i_adv) begin
            r_mul_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_mul_item <= i_item;
            r_p_lo     <= p_lo;
            r_p_hi     <= p_hi;
        end
    end

    // sum, scale back, sign, 32-bit wrap and optional halving toward zero
    always_comb begin
        prod     = (PROD_W'(r_p_hi) << PS_W) + PROD_W'(r_p_lo);
        q32      = DW'(prod >> SH);
        sval     = r_mul_item.shift_ps[PS_W-1] ? (DW'(0) - q32) : q32;
        sval_rnd = sval + {{(DW-1){1'b0}}, sval[DW-1]};
        n_target = i_div_two ? DW'($signed(sval_rnd) >>> 1) : sval;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fin_v <= 1'b0;
        end else if (i_adv) begin
            r_fin_v <= r_mul_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_fin_item   <= r_mul_item;
            r_fin_target <= n_target;
        end
    end

    assign o_valid  = r_fin_v;
    assign o_item   = r_fin_item;
    assign o_target = r_fin_target;

endmodule

@@ src/ddmtd_backup_phase_tracker.sv @@
// ----------------------------------------------------------------------------
// ddmtd_backup_phase_tracker
// Phase tracker of a backup reference clock against the feedback clock.
// ----------------------------------------------------------------------------
// Takes one request per clock unless a result waits to be taken. Each request
// passes through a two-stage reciprocal multiplier (the picosecond-to-tag-unit
// conversion, used only by set-shift requests) and then the state update that
// loads the result register. Requests stay in order; the whole pipeline holds
// while a result waits to be taken, so at most three requests are in flight.
// Register writes are taken every cycle and apply at once, so write them only
// while the block is empty.
module ddmtd_backup_phase_tracker #(
    parameter int TAG_WIDTH       = dbpt_pkg::TAG_WIDTH_DEF,
    parameter int FRAC_BITS       = dbpt_pkg::FRAC_BITS_DEF,
    parameter int CLOCK_PERIOD_PS = dbpt_pkg::CLOCK_PERIOD_PS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    dbpt_in_if.snk         i_in,
    dbpt_out_if.src        o_out,
    dbpt_cfg_if.snk        i_cfg
);

    localparam int DW = dbpt_pkg::DATA_W;
    localparam logic [DW-1:0] WRAP_ADD = DW'(64'd1 << TAG_WIDTH);

    logic              adv;
    dbpt_pkg::t_item   in_item;
    dbpt_pkg::t_cfg    r_cfg;

    logic              lv;
    dbpt_pkg::t_item   litem;
    logic [DW-1:0]     ltarget;

    // tracker state
    logic                  r_running, n_running;
    logic                  r_rh_v, n_rh_v, r_oh_v, n_oh_v;
    logic [TAG_WIDTH-1:0]  r_rh, n_rh, r_oh, n_oh;
    logic                  r_rp_v, n_rp_v, r_op_v, n_op_v;
    logic [TAG_WIDTH-1:0]  r_rp, n_rp, r_op, n_op;
    logic [DW-1:0]         r_ra, n_ra, r_oa, n_oa;
    logic [DW-1:0]         r_perr, n_perr, r_tgt, n_tgt, r_cur, n_cur;

    logic                  r_out_v, r_out_status, r_out_busy;
    logic                  n_status;

    // tag path temporaries
    logic [TAG_WIDTH-1:0]  tag_t;
    logic                  wrap_r, wrap_o, seed, renorm;
    logic [DW-1:0]         ra1, oa1, err_raw, err, tgt1, cur1, ra2, ra3, oa3;

    assign adv         = !r_out_v || o_out.ready;
    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    assign in_item.func     = dbpt_pkg::t_func'(i_in.func);
    assign in_item.source   = i_in.source;
    assign in_item.tag      = i_in.tag;
    assign in_item.shift_ps = i_in.shift_ps;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ref_channel      <= '0;
            r_cfg.out_channel      <= dbpt_pkg::SRC_W'(1);
            r_cfg.lock_mask_enable <= 1'b0;
            r_cfg.divide_by_two    <= 1'b0;
        end else if (i_cfg.valid) begin
            case (dbpt_pkg::t_cfg_idx'(i_cfg.index))
                dbpt_pkg::CFG_REF_CHANNEL: r_cfg.ref_channel      <= i_cfg.data;
                dbpt_pkg::CFG_OUT_CHANNEL: r_cfg.out_channel      <= i_cfg.data;
                dbpt_pkg::CFG_LOCK_MASK:   r_cfg.lock_mask_enable <= i_cfg.data[0];
                dbpt_pkg::CFG_DIV_TWO:     r_cfg.divide_by_two    <= i_cfg.data[0];
                default: ;
            endcase
        end
    end

    dbpt_div_pipe #(
        .FRAC_BITS       (FRAC_BITS),
        .CLOCK_PERIOD_PS (CLOCK_PERIOD_PS)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_adv     (adv),
        .i_valid   (i_in.valid),
        .i_div_two (r_cfg.divide_by_two),
        .i_item    (in_item),
        .o_valid   (lv),
        .o_item    (litem),
        .o_target  (ltarget)
    );

    always_comb begin
        n_running = r_running;
        n_rh_v = r_rh_v;  n_rh = r_rh;  n_oh_v = r_oh_v;  n_oh = r_oh;
        n_rp_v = r_rp_v;  n_rp = r_rp;  n_op_v = r_op_v;  n_op = r_op;
        n_ra = r_ra;  n_oa = r_oa;  n_perr = r_perr;  n_tgt = r_tgt;  n_cur = r_cur;
        n_status = 1'b1;

        tag_t   = TAG_WIDTH'(litem.tag);
        wrap_r  = 1'b0;
        wrap_o  = 1'b0;
        ra1     = r_ra;
        oa1     = r_oa;
        err_raw = '0;
        err     = '0;
        seed    = 1'b0;
        renorm  = 1'b0;
        tgt1    = r_tgt;
        cur1    = r_cur;
        ra2     = r_ra;
        ra3     = r_ra;
        oa3     = r_oa;

        case (litem.func)
            dbpt_pkg::FUNC_TAG: begin
                if (r_running) begin
                    if (litem.source == r_cfg.ref_channel) begin
                        n_rh_v = 1'b1;
                        n_rh   = tag_t;
                    end
                    if (litem.source == r_cfg.out_channel) begin
                        n_oh_v = 1'b1;
                        n_oh   = tag_t;
                    end

                    // a tag below the channel's previous one means the counter wrapped
                    if (n_rh_v) begin
                        wrap_r = r_rp_v && (r_rp > n_rh);
                        n_rp_v = 1'b1;
                        n_rp   = n_rh;
                    end
                    if (n_oh_v) begin
                        wrap_o = r_op_v && (r_op > n_oh);
                        n_op_v = 1'b1;
                        n_op   = n_oh;
                    end
                    ra1  = wrap_r ? (r_ra + WRAP_ADD) : r_ra;
                    oa1  = wrap_o ? (r_oa + WRAP_ADD) : r_oa;
                    n_ra = ra1;
                    n_oa = oa1;

                    if (!(n_rh_v && n_oh_v)) begin
                        n_status = 1'b0;
                    end else begin
                        err_raw = ra1 + DW'(n_rh) - oa1 - DW'(n_oh);
                        err = r_cfg.lock_mask_enable ?
                              {{(DW-FRAC_BITS){err_raw[FRAC_BITS-1]}},
                               err_raw[FRAC_BITS-1:0]} : err_raw;

                        // first nonzero error after start seeds the loop
                        seed = (err != '0) && (r_perr == '0) && (r_cur == '0) &&
                               (ra1 == '0);
                        tgt1 = seed ? (DW'(0) - err) :
                               ((err != '0) ? (r_perr - err) : r_tgt);
                        cur1 = seed ? (DW'(0) - err) : r_cur;
                        ra2  = seed ? (DW'(0) - err) : ra1;

                        renorm = ($signed(ra2) > dbpt_pkg::RENORM_LIMIT) &&
                                 ($signed(oa1) > dbpt_pkg::RENORM_LIMIT);
                        ra3 = renorm ? (ra2 - dbpt_pkg::WRAP_STEP) : ra2;
                        oa3 = renorm ? (oa1 - dbpt_pkg::WRAP_STEP) : oa1;

                        n_tgt = tgt1;
                        n_oa  = oa3;
                        if ($signed(cur1) < $signed(tgt1)) begin
                            n_cur = cur1 + DW'(1);
                            n_ra  = ra3 + DW'(1);
                        end else if ($signed(cur1) > $signed(tgt1)) begin
                            n_cur = cur1 - DW'(1);
                            n_ra  = ra3 - DW'(1);
                        end else begin
                            n_cur = cur1;
                            n_ra  = ra3;
                        end

                        n_perr = err;
                        n_rh_v = 1'b0;
                        n_oh_v = 1'b0;
                    end
                end
            end
            dbpt_pkg::FUNC_SET: begin
                n_tgt = ltarget;
            end
            dbpt_pkg::FUNC_START: begin
                n_ra = '0;  n_oa = '0;
                n_rh_v = 1'b0;  n_oh_v = 1'b0;  n_rp_v = 1'b0;  n_op_v = 1'b0;
                n_perr = '0;  n_tgt = '0;  n_cur = '0;
                n_running = 1'b1;
            end
            dbpt_pkg::FUNC_STOP: begin
                n_running = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= 1'b0;
            r_rh_v    <= 1'b0;
            r_oh_v    <= 1'b0;
            r_rp_v    <= 1'b0;
            r_op_v    <= 1'b0;
            r_ra      <= '0;
            r_oa      <= '0;
            r_perr    <= '0;
            r_tgt     <= '0;
            r_cur     <= '0;
            r_out_v   <= 1'b0;
        end else if (adv) begin
            r_out_v <= lv;
            if (lv) begin
                r_running <= n_running;
                r_rh_v    <= n_rh_v;
                r_oh_v    <= n_oh_v;
                r_rp_v    <= n_rp_v;
                r_op_v    <= n_op_v;
                r_ra      <= n_ra;
                r_oa      <= n_oa;
                r_perr    <= n_perr;
                r_tgt     <= n_tgt;
                r_cur     <= n_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && lv) begin
            r_rh         <= n_rh;
            r_oh         <= n_oh;
            r_rp         <= n_rp;
            r_op         <= n_op;
            r_out_status <= n_status;
            r_out_busy   <= (n_tgt != n_cur);
        end
    end

    // state only moves when a result is loaded, so it doubles as the payload
    assign o_out.valid         = r_out_v;
    assign o_out.status        = r_out_status;
    assign o_out.busy_res      = r_out_busy;
    assign o_out.phase_error   = r_perr;
    assign o_out.current_shift = r_cur;

    a_start_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lv && adv && litem.func == dbpt_pkg::FUNC_START) |=>
        (r_cur == '0 && r_perr == '0 && r_tgt == '0 && r_running))
        else $error("start did not clear tracker state");

    a_locking_only_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_status) |-> r_running)
        else $error("incomplete pair reported while stopped");

    a_pair_consumed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_rh_v && r_oh_v))
        else $error("complete tag pair left unprocessed");

    a_stopped_tag_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (lv && adv && litem.func == dbpt_pkg::FUNC_TAG && !r_running) |=>
        ($stable(r_cur) && $stable(r_ra) && $stable(r_oa) && $stable(r_perr)))
        else $error("tag changed state while stopped");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the backup phase tracker: a queue-fed driver offers
// requests, a request-level predictor builds the expected report of each one,
// and a monitor compares every report taken from the block field by field.
// ----------------------------------------------------------------------------
module testbench;
    import dbpt_pkg::*;

    localparam int TAG_W          = TAG_WIDTH_DEF;
    localparam int FRAC_W         = FRAC_BITS_DEF;
    localparam int PERIOD_PS      = CLOCK_PERIOD_PS_DEF;
    localparam int LATENCY        = 2;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 300;
    localparam int RAND_PHASES    = 5;
    localparam int PHASE_ITEMS    = 340;
    localparam logic [31:0] TAG_MASK = (32'd1 << TAG_W) - 32'd1;

    typedef struct packed {
        logic        status;
        logic        busy;
        logic [31:0] phase_error;
        logic [31:0] shift;
    } t_track_report;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    dbpt_in_if  req_if ();
    dbpt_out_if res_if ();
    dbpt_cfg_if reg_if ();

    ddmtd_backup_phase_tracker dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .i_cfg   (reg_if)
    );

    always #2 i_clk = ~i_clk;

    // Tracker state as predicted
    t_cfg        trk_cfg;
    logic        trk_running;
    logic [31:0] ref_hold, out_hold, ref_last, out_last;
    logic        ref_hold_ok, out_hold_ok, ref_last_ok, out_last_ok;
    logic [31:0] ref_acc, out_acc, last_err, tgt_shift, cur_shift;

    t_item         pending_reqs[$];
    t_track_report expected_reports[$];
    t_item         cur_req;

    int items_queued = 0;
    int results_seen = 0;
    int err_count    = 0;
    int tx_gap_max   = 5;
    int rx_stall_max = 5;
    int tx_wait      = 0;
    int rx_wait      = 0;
    int idle_cycles  = 0;

    function automatic t_track_report track_step(t_item it);
        t_track_report r;
        logic [31:0]   err, m, tag_v;
        longint        q;
        int            v;
        r.status = 1'b1;
        case (it.func)
            FUNC_TAG: begin
                if (trk_running) begin
                    tag_v = 32'(it.tag) & TAG_MASK;
                    if (it.source == trk_cfg.ref_channel) begin
                        ref_hold    = tag_v;
                        ref_hold_ok = 1'b1;
                    end
                    if (it.source == trk_cfg.out_channel) begin
                        out_hold    = tag_v;
                        out_hold_ok = 1'b1;
                    end
                    // a held tag lower than the last one of its channel is a wrap
                    if (ref_hold_ok) begin
                        if (ref_last_ok && ref_last > ref_hold)
                            ref_acc = ref_acc + (32'd1 << TAG_W);
                        ref_last    = ref_hold;
                        ref_last_ok = 1'b1;
                    end
                    if (out_hold_ok) begin
                        if (out_last_ok && out_last > out_hold)
                            out_acc = out_acc + (32'd1 << TAG_W);
                        out_last    = out_hold;
                        out_last_ok = 1'b1;
                    end
                    if (!(ref_hold_ok && out_hold_ok)) begin
                        r.status = 1'b0;
                    end else begin
                        err = ref_acc + ref_hold - out_acc - out_hold;
                        if (trk_cfg.lock_mask_enable) begin
                            m   = (32'd1 << FRAC_W) - 32'd1;
                            err = err & m;
                            if (err[FRAC_W-1])
                                err = err | ~m;
                        end
                        if (err != 0 && last_err == 0 && cur_shift == 0 && ref_acc == 0) begin
                            tgt_shift = 32'd0 - err;
                            cur_shift = 32'd0 - err;
                            ref_acc   = 32'd0 - err;
                        end else if (err != 0) begin
                            tgt_shift = 32'd0 - (err - last_err);
                        end
                        last_err    = err;
                        ref_hold_ok = 1'b0;
                        out_hold_ok = 1'b0;
                        if ($signed(ref_acc) > RENORM_LIMIT && $signed(out_acc) > RENORM_LIMIT) begin
                            ref_acc = ref_acc - WRAP_STEP;
                            out_acc = out_acc - WRAP_STEP;
                        end
                        // slew one step toward the target
                        if ($signed(cur_shift) < $signed(tgt_shift)) begin
                            cur_shift = cur_shift + 32'd1;
                            ref_acc   = ref_acc + 32'd1;
                        end else if ($signed(cur_shift) > $signed(tgt_shift)) begin
                            cur_shift = cur_shift - 32'd1;
                            ref_acc   = ref_acc - 32'd1;
                        end
                    end
                end
            end
            FUNC_SET: begin
                q = longint'(it.shift_ps) * (longint'(1) << FRAC_W) / longint'(PERIOD_PS);
                v = int'(q);
                if (trk_cfg.divide_by_two)
                    v = v / 2;
                tgt_shift = v;
            end
            FUNC_START: begin
                ref_acc     = '0;
                out_acc     = '0;
                ref_hold_ok = 1'b0;
                out_hold_ok = 1'b0;
                ref_last_ok = 1'b0;
                out_last_ok = 1'b0;
                last_err    = '0;
                tgt_shift   = '0;
                cur_shift   = '0;
                trk_running = 1'b1;
            end
            default: trk_running = 1'b0;
        endcase
        r.busy        = (tgt_shift != cur_shift);
        r.phase_error = last_err;
        r.shift       = cur_shift;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic signed [31:0] got,
                                   logic signed [31:0] want);
        $display("mismatch on %s at report %0d: got %0d, want %0d",
                 what, results_seen, got, want);
        err_count++;
    endtask

    task automatic queue_req(t_func f, logic [SRC_W-1:0] src, logic [TAG_IN_W-1:0] tg,
                             logic [SHIFT_PS_W-1:0] ps);
        t_item it;
        it.func     = f;
        it.source   = src;
        it.tag      = tg;
        it.shift_ps = ps;
        pending_reqs.push_back(it);
        items_queued++;
    endtask

    task automatic queue_tag(logic [SRC_W-1:0] src, logic [TAG_IN_W-1:0] tg);
        queue_req(FUNC_TAG, src, tg, SHIFT_PS_W'($urandom));
    endtask

    task automatic queue_cmd(t_func f);
        queue_req(f, SRC_W'($urandom), TAG_IN_W'($urandom), SHIFT_PS_W'($urandom));
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        reg_if.valid <= 1'b1;
        reg_if.index <= idx;
        reg_if.data  <= val;
        do @(posedge i_clk); while (!reg_if.ready);
        reg_if.valid <= 1'b0;
        case (idx)
            CFG_REF_CHANNEL: trk_cfg.ref_channel      = val;
            CFG_OUT_CHANNEL: trk_cfg.out_channel      = val;
            CFG_LOCK_MASK:   trk_cfg.lock_mask_enable = val[0];
            default:         trk_cfg.divide_by_two    = val[0];
        endcase
    endtask

    task automatic wait_drained();
        while (results_seen != items_queued) @(posedge i_clk);
    endtask

    // Tag pairs of two drifting clocks, with dropped, extra and foreign requests mixed in
    task automatic run_track(int pairs, logic [SRC_W-1:0] rch, logic [SRC_W-1:0] och);
        logic [TAG_IN_W-1:0] rt, ot, step, offset;
        int                  r;
        t_func               f;
        rt     = TAG_IN_W'($urandom);
        step   = ($urandom_range(0, 3) == 0) ? TAG_IN_W'($urandom_range(1, 4096))
                                             : TAG_IN_W'($urandom_range(3 * 2**20, 2**22 - 1));
        offset = ($urandom_range(0, 3) == 0) ? TAG_IN_W'($urandom)
                                             : TAG_IN_W'($urandom_range(0, 2000));
        for (int k = 0; k < pairs; k++) begin
            rt = TAG_IN_W'(rt + step + $urandom_range(0, 255));
            ot = TAG_IN_W'(rt - offset + $urandom_range(0, 16) - 8);
            r  = $urandom_range(0, 99);
            if (r < 3) begin
                f = t_func'($urandom_range(0, 3));
                queue_cmd(f);
                if (f == FUNC_STOP) begin
                    queue_tag(rch, rt);
                    queue_cmd(FUNC_START);
                end
            end else if (r < 7) begin
                queue_req(FUNC_SET, SRC_W'($urandom), TAG_IN_W'($urandom),
                          SHIFT_PS_W'($urandom));
            end else if (r < 10) begin
                queue_tag(SRC_W'($urandom), TAG_IN_W'($urandom));
            end else if (r < 13) begin
                queue_tag(rch, rt);
            end else if ($urandom_range(0, 1)) begin
                queue_tag(rch, rt);
                queue_tag(och, ot);
            end else begin
                queue_tag(och, ot);
                queue_tag(rch, rt);
            end
        end
    endtask

    // Request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                expected_reports.push_back(track_step(cur_req));
                tx_wait = $urandom_range(0, tx_gap_max);
            end
            if (!req_if.valid || req_if.ready) begin
                if (tx_wait == 0 && pending_reqs.size() > 0) begin
                    cur_req = pending_reqs.pop_front();
                    req_if.valid    <= 1'b1;
                    req_if.func     <= cur_req.func;
                    req_if.source   <= cur_req.source;
                    req_if.tag      <= cur_req.tag;
                    req_if.shift_ps <= cur_req.shift_ps;
                end else begin
                    req_if.valid <= 1'b0;
                    if (tx_wait > 0)
                        tx_wait--;
                end
            end
        end
    end

    // Report monitor
    always @(posedge i_clk) begin
        t_track_report want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
            rx_wait = 0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("report with no request outstanding", 0, 0);
                end else begin
                    want = expected_reports.pop_front();
                    if (res_if.status !== want.status)
                        report_mismatch("status", 32'(res_if.status), 32'(want.status));
                    if (res_if.busy_res !== want.busy)
                        report_mismatch("busy_res", 32'(res_if.busy_res), 32'(want.busy));
                    if (res_if.phase_error !== want.phase_error)
                        report_mismatch("phase_error", res_if.phase_error, want.phase_error);
                    if (res_if.current_shift !== want.shift)
                        report_mismatch("current_shift", res_if.current_shift, want.shift);
                end
                // long hold-off so the pipeline fills and backs up the input
                if (results_seen == 400 || results_seen == 1300)
                    rx_wait = HOLD_CYCLES;
                else
                    rx_wait = $urandom_range(0, rx_stall_max);
                results_seen <= results_seen + 1;
            end
            if (rx_wait > 0) begin
                res_if.ready <= 1'b0;
                rx_wait--;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && !(req_if.valid && req_if.ready) && !(res_if.valid && res_if.ready)
                && !(reg_if.valid && reg_if.ready)) begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end else begin
            idle_cycles = 0;
        end
    end

    initial begin
        logic [SRC_W-1:0] rch, och;
        int               phase_base, left, pairs;

        req_if.valid    = 1'b0;
        req_if.func     = '0;
        req_if.source   = '0;
        req_if.tag      = '0;
        req_if.shift_ps = '0;
        res_if.ready    = 1'b0;
        reg_if.valid    = 1'b0;
        reg_if.index    = '0;
        reg_if.data     = '0;

        trk_cfg     = '{ref_channel: 5'd0, out_channel: 5'd1,
                        lock_mask_enable: 1'b0, divide_by_two: 1'b0};
        trk_running = 1'b0;
        ref_hold_ok = 1'b0;
        out_hold_ok = 1'b0;
        ref_last_ok = 1'b0;
        out_last_ok = 1'b0;
        ref_hold    = '0;
        out_hold    = '0;
        ref_last    = '0;
        out_last    = '0;
        ref_acc     = '0;
        out_acc     = '0;
        last_err    = '0;
        tgt_shift   = '0;
        cur_shift   = '0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: default channels 0 and 1
        queue_tag(5'd0, 22'h12345);                     // tag while stopped
        queue_req(FUNC_SET, 5'd0, 22'd0, 24'sh7FFFFF);  // largest shift
        queue_req(FUNC_SET, 5'd0, 22'd0, 24'sh800000);  // most negative shift
        queue_cmd(FUNC_STOP);
        queue_cmd(FUNC_START);
        queue_tag(5'd0, 22'h3FFFFF);                    // half pair
        queue_tag(5'd1, 22'h000100);                    // pair completes, seeds
        queue_tag(5'd1, 22'h000000);                    // out channel wraps
        queue_tag(5'd7, 22'h2AAAAA);                    // foreign channel
        queue_tag(5'd0, 22'h000010);                    // ref wraps, pair
        queue_tag(5'd0, 22'h155555);
        queue_tag(5'd0, 22'h000020);                    // overwrites held ref tag
        queue_tag(5'd1, 22'h3FFFFF);
        queue_req(FUNC_SET, 5'd0, 22'd0, 24'sd0);
        queue_req(FUNC_SET, 5'd0, 22'd0, -24'sd1);
        queue_cmd(FUNC_STOP);
        queue_tag(5'd1, 22'h000001);                    // ignored while stopped
        queue_cmd(FUNC_START);
        wait_drained();

        // Same channel for both, masked error, halved shift
        write_reg(CFG_REF_CHANNEL, 5'd31);
        write_reg(CFG_OUT_CHANNEL, 5'd31);
        write_reg(CFG_LOCK_MASK, 5'd1);
        write_reg(CFG_DIV_TWO, 5'd1);
        queue_tag(5'd31, 22'h2ABCDE);
        queue_tag(5'd31, 22'h000001);
        queue_req(FUNC_SET, 5'd0, 22'd0, 24'sh800000);
        queue_req(FUNC_SET, 5'd0, 22'd0, -24'sd2441);   // odd negative, rounds toward zero
        queue_tag(5'd5, 22'h0F0F0F);
        queue_cmd(FUNC_STOP);

        for (int p = 0; p < RAND_PHASES; p++) begin
            wait_drained();
            case (p)
                0: begin
                    rch = 5'd0;
                    och = 5'd31;
                end
                1: begin
                    rch = 5'd31;
                    och = 5'd0;
                end
                2: begin
                    rch = SRC_W'($urandom);
                    och = rch;
                end
                default: begin
                    rch = SRC_W'($urandom);
                    och = rch ^ 5'($urandom_range(1, 31));
                end
            endcase
            write_reg(CFG_REF_CHANNEL, rch);
            write_reg(CFG_OUT_CHANNEL, och);
            write_reg(CFG_LOCK_MASK, (p == 0) ? 5'd0 : (p == 1) ? 5'd1 : 5'($urandom_range(0, 1)));
            write_reg(CFG_DIV_TWO, (p == 0) ? 5'd0 : (p == 1) ? 5'd1 : 5'($urandom_range(0, 1)));
            case (p % 3)
                0: begin
                    tx_gap_max   = 0;
                    rx_stall_max = 0;
                end
                1: begin
                    tx_gap_max   = 5;
                    rx_stall_max = 5;
                end
                default: begin
                    tx_gap_max   = 0;
                    rx_stall_max = 5;
                end
            endcase
            phase_base = items_queued;
            queue_cmd(FUNC_START);
            while (items_queued - phase_base < PHASE_ITEMS) begin
                if ($urandom_range(0, 2) == 0)
                    queue_cmd(FUNC_START);
                left  = PHASE_ITEMS - (items_queued - phase_base);
                pairs = $urandom_range(20, 150);
                if (pairs > left / 2 + 1)
                    pairs = left / 2 + 1;
                run_track(pairs, rch, och);
            end
        end

        wait_drained();
        repeat (LATENCY + 10) @(posedge i_clk);
        if (expected_reports.size() != 0)
            report_mismatch("requests left without report", expected_reports.size(), 0);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

@@ filelist.f @@
src/dbpt_pkg.sv
src/dbpt_if.sv
src/dbpt_div_pipe.sv
src/ddmtd_backup_phase_tracker.sv
test/testbench.sv
